>>> rtl/core/roac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roac_pkg
// Shared codes, field widths and the divide-by-255 helper for the rotated
// overlay compositor.
// ----------------------------------------------------------------------------
package roac_pkg;

  // Fixed field widths
  localparam int REQ_W       = 1;
  localparam int LOAD_IDX_W  = 12;
  localparam int RGBA_W      = 32;
  localparam int COORD_W     = 6;
  localparam int RGB_W       = 24;
  localparam int ALPHA_W     = 8;
  localparam int CHAN_W      = 8;
  localparam int ROT_W       = 2;
  localparam int SIDE_CFG_W  = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD      = 1'b0;
  localparam logic [REQ_W-1:0] REQ_COMPOSITE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

  // Rotation codes
  localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

  // Reset values
  localparam logic [ROT_W-1:0]      ROTATION_RST = ROT_NONE;
  localparam logic [SIDE_CFG_W-1:0] SIDE_RST     = 7'd64;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'hff;
  localparam logic [CHAN_W-1:0]  OUT_ALPHA   = 8'hff;

  // Exact floor(x / 255) for x up to 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
    logic [2*CHAN_W:0] t;
    t = {1'b0, x} + (2*CHAN_W+1)'(x[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

>>> rtl/core/roac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roac_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module roac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> rtl/core/roac_coord_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roac_coord_map
// Maps a framebuffer coordinate to the upright overlay under the current
// rotation, flags out-of-range points and forms the store address.
// ----------------------------------------------------------------------------
module roac_coord_map #(
  parameter int MAX_SIDE = 64
) (
  input  logic [roac_pkg::ROT_W-1:0]                  rotation,
  input  logic [roac_pkg::SIDE_CFG_W-1:0]             width_cfg,
  input  logic [roac_pkg::SIDE_CFG_W-1:0]             height_cfg,
  input  logic [roac_pkg::COORD_W-1:0]                dest_x,
  input  logic [roac_pkg::COORD_W-1:0]                dest_y,
  output logic                                        in_range,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]        addr
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int CW = ((SW > roac_pkg::COORD_W) ? SW : roac_pkg::COORD_W) + 2;
  localparam logic signed [CW-1:0] ONE = CW'(1);

  logic [SW-1:0]          w;
  logic [SW-1:0]          h;
  logic signed [CW-1:0]   w_s;
  logic signed [CW-1:0]   h_s;
  logic signed [CW-1:0]   dx_s;
  logic signed [CW-1:0]   dy_s;
  logic signed [CW-1:0]   lx;
  logic signed [CW-1:0]   ly;
  logic [2*SW-1:0]        row_base;

  // Oversized dimensions act as the full side
  assign w = (32'(width_cfg) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(width_cfg);
  assign h = (32'(height_cfg) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(height_cfg);

  assign w_s  = signed'(CW'(w));
  assign h_s  = signed'(CW'(h));
  assign dx_s = signed'(CW'(dest_x));
  assign dy_s = signed'(CW'(dest_y));

  always_comb begin
    case (rotation)
      roac_pkg::ROT_90: begin
        lx = dy_s;
        ly = h_s - ONE - dx_s;
      end
      roac_pkg::ROT_180: begin
        lx = w_s - ONE - dx_s;
        ly = h_s - ONE - dy_s;
      end
      roac_pkg::ROT_270: begin
        lx = w_s - ONE - dy_s;
        ly = dx_s;
      end
      default: begin
        lx = dx_s;
        ly = dy_s;
      end
    endcase
  end

  assign in_range = !lx[CW-1] && !ly[CW-1] && (lx < w_s) && (ly < h_s);

  // Only meaningful when in range, where lx and ly fit in SW bits
  assign row_base = ly[SW-1:0] * w;
  assign addr     = AW'(row_base + (2*SW)'(lx[SW-1:0]));

endmodule

>>> rtl/core/roac_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roac_blend
// Straight-alpha over blend: registers the weighted channel sums, then
// divides each by 255.
// ----------------------------------------------------------------------------
module roac_blend (
  input  logic                            clk,
  input  logic                            load,
  input  logic [roac_pkg::RGB_W-1:0]      src_rgb,
  input  logic [roac_pkg::ALPHA_W-1:0]    alpha,
  input  logic [roac_pkg::RGB_W-1:0]      dst_rgb,
  output logic [roac_pkg::RGB_W-1:0]      rgb_out
);

  localparam int NCH = 3;
  localparam int CH  = roac_pkg::CHAN_W;

  logic [CH-1:0]   inv_alpha;
  logic [2*CH-1:0] sum_next [NCH];
  logic [2*CH-1:0] sum      [NCH];

  assign inv_alpha = roac_pkg::ALPHA_FULL - alpha;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      sum_next[i] = (2*CH)'(src_rgb[i*CH +: CH]) * (2*CH)'(alpha)
                  + (2*CH)'(dst_rgb[i*CH +: CH]) * (2*CH)'(inv_alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      rgb_out[i*CH +: CH] = roac_pkg::div255(sum[i]);
    end
  end

endmodule

>>> rtl/core/rotated_overlay_alpha_compositor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_overlay_alpha_compositor_top
// Overlay store plus rotated lookup and alpha-over blend of framebuffer pixels.
// ----------------------------------------------------------------------------
// Sequence: a load writes the store when accepted and gives no result. A
//   composite reads the overlay RAM at the accepting edge, registers the
//   channel sums, then divides by 255 into the output register once free.
// Throughput: one load per cycle while no composite is in flight; a new
//   request waits out the read-multiply-divide sequence on the single RAM port.
// Reset: rst (synchronous) clears the sequencer, the output valid and the
//   registers (rotation 0, width 64, height 64). The overlay store is not
//   cleared and holds nothing meaningful until loaded.
// ----------------------------------------------------------------------------
module rotated_overlay_alpha_compositor_top #(
  parameter int MAX_SIDE = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [roac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [roac_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [roac_pkg::REQ_W-1:0]           req_type,
  input  logic [roac_pkg::LOAD_IDX_W-1:0]      load_index,
  input  logic [roac_pkg::RGBA_W-1:0]          overlay_rgba,
  input  logic [roac_pkg::COORD_W-1:0]         dest_x,
  input  logic [roac_pkg::COORD_W-1:0]         dest_y,
  input  logic [roac_pkg::RGB_W-1:0]           fb_pixel,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [roac_pkg::RGBA_W-1:0]          pixel_out,
  output logic                                 write_enable
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  // One-hot sequencer for a composite transaction
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [roac_pkg::ROT_W-1:0]      rotation;
  logic [roac_pkg::SIDE_CFG_W-1:0] logical_width;
  logic [roac_pkg::SIDE_CFG_W-1:0] logical_height;

  logic                        accept;
  logic                        is_load;
  logic                        load_ok;
  logic                        map_in_range;
  logic [AW-1:0]               map_addr;
  logic                        ram_en;
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [roac_pkg::RGBA_W-1:0] ram_rdata;

  // Held context of the composite in flight
  logic [roac_pkg::RGB_W-1:0]  fb_hold;
  logic                        range_hold;
  logic                        hit;
  logic                        blend_load;
  logic [roac_pkg::RGB_W-1:0]  blend_rgb;
  logic                        out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_load   = (req_type == roac_pkg::REQ_LOAD);
  assign out_free  = !out_valid || out_ready;

  // --------------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation       <= roac_pkg::ROTATION_RST;
      logical_width  <= roac_pkg::SIDE_RST;
      logical_height <= roac_pkg::SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        roac_pkg::REG_ROTATION: rotation       <= cfg_data[roac_pkg::ROT_W-1:0];
        roac_pkg::REG_WIDTH:    logical_width  <= cfg_data;
        roac_pkg::REG_HEIGHT:   logical_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Coordinate mapping, computed straight off the request payload so the
  // RAM read can be issued in the acceptance cycle
  // --------------------------------------------------------------------------
  roac_coord_map #(
    .MAX_SIDE(MAX_SIDE)
  ) u_coord_map (
    .rotation  (rotation),
    .width_cfg (logical_width),
    .height_cfg(logical_height),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .in_range  (map_in_range),
    .addr      (map_addr)
  );

  // Loads beyond the store are dropped
  assign load_ok  = (32'(load_index) < DEPTH);

  // Single port: a load writes, a composite reads, both only when accepted
  assign ram_we   = accept && is_load && load_ok;
  assign ram_en   = ram_we || (accept && !is_load && map_in_range);
  assign ram_addr = is_load ? AW'(load_index) : map_addr;

  roac_ram #(
    .WIDTH(roac_pkg::RGBA_W),
    .DEPTH(DEPTH)
  ) u_overlay_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(overlay_rgba),
    .rdata(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Blend datapath: sums registered in ST_MUL, quotient read in ST_DIV
  // --------------------------------------------------------------------------
  assign blend_load = (state == ST_MUL);

  roac_blend u_blend (
    .clk    (clk),
    .load   (blend_load),
    .src_rgb(ram_rdata[roac_pkg::RGBA_W-1:roac_pkg::ALPHA_W]),
    .alpha  (ram_rdata[roac_pkg::ALPHA_W-1:0]),
    .dst_rgb(fb_hold),
    .rgb_out(blend_rgb)
  );

  // Hold the framebuffer pixel and range flag of the accepted composite
  always_ff @(posedge clk) begin
    if (accept && !is_load) begin
      fb_hold    <= fb_pixel;
      range_hold <= map_in_range;
    end
  end

  // Alpha 0 or out of range: leave the pixel alone. Alpha 255 falls out of
  // the blend exactly, so it needs no path of its own.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      hit <= range_hold && (ram_rdata[roac_pkg::ALPHA_W-1:0] != '0);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !is_load) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register; a waiting result does not block new loads
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DIV && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && out_free) begin
      pixel_out    <= {roac_pkg::OUT_ALPHA, hit ? blend_rgb : fb_hold};
      write_enable <= hit;
    end
  end

`ifndef ASSERT_OFF
  // A composite enters the multiply step right after acceptance
  assert property (@(posedge clk) disable iff (rst)
    (accept && !is_load) |=> (state == ST_MUL))
    else $error("composite did not advance to multiply");

  // The multiply step always moves on to the divide step
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_DIV))
    else $error("multiply step did not advance");

  // The store is written only while no composite is in flight
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE))
    else $error("overlay write during composite");

  // Leaving the divide step always presents a result
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not presented");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotated overlay alpha compositor. Loads
// overlay entries, composites framebuffer pixels under a range of rotation
// and size settings and compares every result with a local blend predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int STORE_SIDE    = 64;
  localparam int STORE_DEPTH   = STORE_SIDE * STORE_SIDE;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 225;
  localparam int NUM_PHASES    = 8;

  typedef logic [roac_pkg::REQ_W-1:0]      req_t;
  typedef logic [roac_pkg::LOAD_IDX_W-1:0] load_idx_t;
  typedef logic [roac_pkg::RGBA_W-1:0]     rgba_t;
  typedef logic [roac_pkg::COORD_W-1:0]    coord_t;
  typedef logic [roac_pkg::RGB_W-1:0]      rgb_t;
  typedef logic [roac_pkg::ALPHA_W-1:0]    alpha_t;
  typedef logic [roac_pkg::CHAN_W-1:0]     chan_t;
  typedef logic [roac_pkg::ROT_W-1:0]      rot_t;
  typedef logic [roac_pkg::SIDE_CFG_W-1:0] side_t;
  typedef logic [roac_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [roac_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // Register slot past the end of the map; writes to it must change nothing
  localparam cfg_idx_t REG_SPARE = 2'd3;

  typedef struct packed {
    rgba_t pixel;
    logic  we;
  } blend_result_t;

  // --------------------------------------------------------------------------
  // Blend predictor and result checker
  // --------------------------------------------------------------------------
  class overlay_blend_scoreboard;
    rgba_t         overlay_mem [STORE_DEPTH];
    rot_t          rotation;
    side_t         width_cfg;
    side_t         height_cfg;
    blend_result_t expected_pixels [$];
    int            errors;

    function new();
      rotation   = roac_pkg::ROTATION_RST;
      width_cfg  = roac_pkg::SIDE_RST;
      height_cfg = roac_pkg::SIDE_RST;
      errors     = 0;
    endfunction

    // Map a framebuffer coordinate to a store entry; returns 0 when the
    // coordinate lands outside the upright image.
    static function bit store_index(rot_t rot, side_t w_cfg, side_t h_cfg,
                                    coord_t dx, coord_t dy, output int idx);
      int w, h, lx, ly;
      w = (w_cfg > STORE_SIDE) ? STORE_SIDE : int'(w_cfg);
      h = (h_cfg > STORE_SIDE) ? STORE_SIDE : int'(h_cfg);
      case (rot)
        roac_pkg::ROT_90: begin
          lx = dy;
          ly = h - 1 - dx;
        end
        roac_pkg::ROT_180: begin
          lx = w - 1 - dx;
          ly = h - 1 - dy;
        end
        roac_pkg::ROT_270: begin
          lx = w - 1 - dy;
          ly = dx;
        end
        default: begin
          lx = dx;
          ly = dy;
        end
      endcase
      idx = ly * w + lx;
      return (lx >= 0 && ly >= 0 && lx < w && ly < h);
    endfunction

    static function chan_t mix(int s, int d, int a);
      return chan_t'((s * a + d * (255 - a)) / 255);
    endfunction

    function void write_register(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        roac_pkg::REG_ROTATION: rotation   = data[roac_pkg::ROT_W-1:0];
        roac_pkg::REG_WIDTH:    width_cfg  = data;
        roac_pkg::REG_HEIGHT:   height_cfg = data;
        default: ;
      endcase
    endfunction

    function void note_request(req_t req, load_idx_t load_idx, rgba_t rgba,
                               coord_t dx, coord_t dy, rgb_t fb);
      blend_result_t res;
      rgba_t src;
      alpha_t a;
      int idx;
      if (req == roac_pkg::REQ_LOAD) begin
        overlay_mem[load_idx] = rgba;
        return;
      end
      res.pixel = {roac_pkg::OUT_ALPHA, fb};
      res.we    = 1'b0;
      if (store_index(rotation, width_cfg, height_cfg, dx, dy, idx)) begin
        src = overlay_mem[idx];
        a   = src[roac_pkg::ALPHA_W-1:0];
        if (a == roac_pkg::ALPHA_FULL) begin
          res.pixel = {roac_pkg::OUT_ALPHA, src[31:8]};
          res.we    = 1'b1;
        end else if (a != '0) begin
          res.pixel = {roac_pkg::OUT_ALPHA, mix(src[31:24], fb[23:16], a),
                       mix(src[23:16], fb[15:8], a), mix(src[15:8], fb[7:0], a)};
          res.we    = 1'b1;
        end
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_pixel(rgba_t pixel, logic we);
      blend_result_t exp_r;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual pixel %h we %b",
                 $time, pixel, we);
        return;
      end
      exp_r = expected_pixels.pop_front();
      if (pixel !== exp_r.pixel) begin
        errors++;
        $display("%0t: pixel_out mismatch: expected %h actual %h",
                 $time, exp_r.pixel, pixel);
      end
      if (we !== exp_r.we) begin
        errors++;
        $display("%0t: write_enable mismatch: expected %b actual %b",
                 $time, exp_r.we, we);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;
  logic      in_valid;
  logic      in_ready;
  req_t      req_type;
  load_idx_t load_index;
  rgba_t     overlay_rgba;
  coord_t    dest_x;
  coord_t    dest_y;
  rgb_t      fb_pixel;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rgba_t     pixel_out;
  logic      write_enable;

  rotated_overlay_alpha_compositor_top #(
    .MAX_SIDE(STORE_SIDE)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .load_index   (load_index),
    .overlay_rgba (overlay_rgba),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .fb_pixel     (fb_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .write_enable (write_enable)
  );

  overlay_blend_scoreboard blend_sb;

  // Stimulus-side view of the configuration and of which entries hold data.
  // Kept apart from the predictor so generation never races the monitor.
  rot_t  cur_rot;
  side_t cur_w;
  side_t cur_h;
  bit    loaded [STORE_DEPTH];

  int idle_pct;
  int stall_pct;
  int cycle_count = 0;
  int items_sent;
  int phase_start;
  bit phase_held;

  // Per-phase settings: extremes of each register, oversized and zero sides
  rot_t  phase_rot [NUM_PHASES] =
    '{roac_pkg::ROT_NONE, roac_pkg::ROT_90, roac_pkg::ROT_180, roac_pkg::ROT_270,
      roac_pkg::ROT_90, roac_pkg::ROT_180, roac_pkg::ROT_270, roac_pkg::ROT_NONE};
  side_t phase_w [NUM_PHASES] =
    '{7'd64, 7'd64, 7'd17, 7'd1, 7'd127, 7'd0, 7'd64, 7'd40};
  side_t phase_h [NUM_PHASES] =
    '{7'd64, 7'd64, 7'd40, 7'd1, 7'd5, 7'd33, 7'd2, 7'd127};
  // Idle modes: none, sender idle, receiver stall, both
  int mode_idle  [4] = '{0, 74, 0, 25};
  int mode_stall [4] = '{0, 0, 74, 25};

  // --------------------------------------------------------------------------
  // Clock, watchdog, receiver back-pressure
  // --------------------------------------------------------------------------
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Kill the run if the stimulus or the drain hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result channel at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: sample all three channels on the edge where the DUT sees them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        blend_sb.write_register(cfg_index, cfg_data);
      if (out_valid && out_ready)
        blend_sb.check_pixel(pixel_out, write_enable);
      if (in_valid && in_ready)
        blend_sb.note_request(req_type, load_index, overlay_rgba, dest_x, dest_y,
                              fb_pixel);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one request transaction and hold it until it is taken. Idle
  // cycles go in front, so valid drops only between transactions.
  task automatic push_request(req_t req, load_idx_t li, rgba_t rgba, coord_t dx,
                              coord_t dy, rgb_t fb);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    load_index   <= li;
    overlay_rgba <= rgba;
    dest_x       <= dx;
    dest_y       <= dy;
    fb_pixel     <= fb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Pick alpha with weight on the no-write, replace and near-edge cases
  function automatic rgba_t rand_rgba();
    rgba_t v;
    int sel;
    v   = $urandom();
    sel = $urandom_range(9);
    case (sel)
      0, 1:    v[7:0] = 8'h00;
      2, 3:    v[7:0] = roac_pkg::ALPHA_FULL;
      4:       v[7:0] = 8'h01;
      5:       v[7:0] = 8'hfe;
      default: v[7:0] = alpha_t'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Load one overlay entry; composite-only fields carry noise
  task automatic load_entry(load_idx_t idx, rgba_t rgba);
    loaded[idx] = 1'b1;
    push_request(roac_pkg::REQ_LOAD, idx, rgba, coord_t'($urandom_range(63)),
                 coord_t'($urandom_range(63)), rgb_t'($urandom()));
  endtask

  // Composite one pixel. If it would read an empty entry, load that entry
  // first so the lookup always hits written data.
  task automatic composite(coord_t dx, coord_t dy, rgb_t fb);
    int idx;
    if (overlay_blend_scoreboard::store_index(cur_rot, cur_w, cur_h, dx, dy, idx)
        && !loaded[idx])
      load_entry(load_idx_t'(idx), rand_rgba());
    push_request(roac_pkg::REQ_COMPOSITE, load_idx_t'($urandom_range(4095)),
                 rgba_t'($urandom()), dx, dy, fb);
  endtask

  // Stop sending, wait out every pending result, then let a trailing load
  // retire before anything else touches the block.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blend_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last)
      cfg_valid <= 1'b0;
  endtask

  // Reprogram all registers while idle. Upper bits of the rotation write and
  // the spare slot get noise; neither may change the behavior.
  task automatic set_config(rot_t rot, side_t w, side_t h);
    cfg_data_t rot_data;
    drain_results();
    rot_data = cfg_data_t'($urandom());
    rot_data[roac_pkg::ROT_W-1:0] = rot;
    cfg_write(roac_pkg::REG_ROTATION, rot_data, 1'b0);
    cfg_write(roac_pkg::REG_WIDTH, w, 1'b0);
    cfg_write(roac_pkg::REG_HEIGHT, h, 1'b0);
    cfg_write(REG_SPARE, cfg_data_t'($urandom()), 1'b1);
    cur_rot = rot;
    cur_w   = w;
    cur_h   = h;
  endtask

  // A random load or composite; composites mostly use coordinates inside the rotated image footprint, some anywhere
  task automatic random_item();
    int w, h, ex, ey;
    coord_t dx, dy;
    if ($urandom_range(99) < 30) begin
      load_entry(load_idx_t'($urandom_range(4095)), rand_rgba());
    end else begin
      w  = (cur_w > STORE_SIDE) ? STORE_SIDE : int'(cur_w);
      h  = (cur_h > STORE_SIDE) ? STORE_SIDE : int'(cur_h);
      ex = (cur_rot == roac_pkg::ROT_90 || cur_rot == roac_pkg::ROT_270) ? h : w;
      ey = (cur_rot == roac_pkg::ROT_90 || cur_rot == roac_pkg::ROT_270) ? w : h;
      if (ex > 0 && ey > 0 && $urandom_range(99) < 75) begin
        dx = coord_t'($urandom_range(ex - 1));
        dy = coord_t'($urandom_range(ey - 1));
      end else begin
        dx = coord_t'($urandom_range(63));
        dy = coord_t'($urandom_range(63));
      end
      composite(dx, dy, rgb_t'($urandom()));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    blend_sb     = new();
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    req_type     = roac_pkg::REQ_LOAD;
    load_index   = '0;
    overlay_rgba = '0;
    dest_x       = '0;
    dest_y       = '0;
    fb_pixel     = '0;
    idle_pct     = 25;
    stall_pct    = 25;
    items_sent   = 0;
    phase_start  = 0;
    phase_held   = 1'b0;
    cur_rot      = roac_pkg::ROTATION_RST;
    cur_w        = roac_pkg::SIDE_RST;
    cur_h        = roac_pkg::SIDE_RST;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, corners of the store, every alpha class
    load_entry(12'd0,    32'h123456ff);   // replace
    load_entry(12'd4095, 32'hffffff00);   // transparent
    load_entry(12'd1,    32'hffffff80);   // half blend
    load_entry(12'd63,   32'h00000001);   // faintest blend
    load_entry(12'd4032, 32'hfffffffe);
    load_entry(12'd2,    32'h80402054);
    composite(6'd0,  6'd0,  24'h000000);
    composite(6'd63, 6'd63, 24'hffffff);
    composite(6'd1,  6'd0,  24'h000000);
    composite(6'd63, 6'd0,  24'hffffff);
    composite(6'd0,  6'd63, 24'h000000);
    composite(6'd2,  6'd0,  24'h123456);

    // Each rotation at full size, hitting the image corners
    set_config(roac_pkg::ROT_270, 7'd64, 7'd64);
    composite(6'd0,  6'd0,  24'hffffff);
    composite(6'd63, 6'd63, 24'h000000);
    set_config(roac_pkg::ROT_90, 7'd64, 7'd64);
    composite(6'd0,  6'd0,  24'h0000ff);
    composite(6'd63, 6'd0,  24'hff0000);
    set_config(roac_pkg::ROT_180, 7'd64, 7'd64);
    composite(6'd0,  6'd0,  24'h00ff00);
    composite(6'd63, 6'd63, 24'hffffff);

    // One-pixel image: the subtraction goes negative just past the corner
    set_config(roac_pkg::ROT_180, 7'd1, 7'd1);
    composite(6'd0, 6'd0, 24'h5a5a5a);
    composite(6'd1, 6'd0, 24'ha5a5a5);
    composite(6'd0, 6'd1, 24'hffffff);

    // Random phases: each setting under one idle mode, every mode twice.
    // A phase ends after a fixed number of sent transactions.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(phase_rot[p], phase_w[p], phase_h[p]);
      idle_pct    = mode_idle[p % 4];
      stall_pct   = mode_stall[p % 4];
      phase_start = items_sent;
      phase_held  = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        random_item();
        // Hold the sender once per phase until the pipe is empty
        if (!phase_held && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          drain_results();
          phase_held = 1'b1;
        end
      end
    end

    drain_results();
    if (blend_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/roac_pkg.sv
rtl/core/roac_ram.sv
rtl/core/roac_coord_map.sv
rtl/core/roac_blend.sv
rtl/core/rotated_overlay_alpha_compositor_top.sv
tb/tb.sv
